FILE: src/cmh_pkg.sv
// ----------------------------------------------------------------------------
// cmh_pkg
// Shared types and constants for the case-folded 64-bit murmur hash block.
// ----------------------------------------------------------------------------
package cmh_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT = 47;

  localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
  localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_LEN,
    ST_MIX,
    ST_K1,
    ST_K2,
    ST_H,
    ST_END,
    ST_FIN
  } seq_state_e;

  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic        busy;
    logic [63:0] product;
  } mul_rsp_t;

  // ASCII fold of the valid bytes; bytes at or past the count read as zero
  function automatic logic [63:0] fold_word(input logic [63:0] w, input logic [3:0] cnt);
    logic [63:0] res;
    logic [7:0]  b;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      b = w[8*i +: 8];
      if (4'(i) >= cnt) begin
        b = 8'h00;
      end else if (b >= 8'h41 && b <= 8'h5a) begin
        b = b + 8'h20;
      end
      res[8*i +: 8] = b;
    end
    return res;
  endfunction

  function automatic logic [63:0] xor_shift(input logic [63:0] v);
    return v ^ (v >> MIX_SHIFT);
  endfunction

endpackage

FILE: src/cmh_mul.sv
// ----------------------------------------------------------------------------
// cmh_mul
// Iterative multiply by the mix constant, low 64 bits of the product.
// One 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module cmh_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmh_pkg::mul_req_t req_i,
  output cmh_pkg::mul_rsp_t rsp_o
);
  import cmh_pkg::*;

  localparam logic [1:0] LastStep = 2'd2;

  logic [63:0] a_q;
  logic [63:0] acc_q, acc_d;
  logic [1:0]  step_q;
  logic        busy_q;
  logic [31:0] x, y;
  logic [63:0] prod;

  // aL*mL + ((aL*mH + aH*mL) << 32), high cross terms drop out
  always_comb begin
    case (step_q)
      2'd0: begin
        x = a_q[31:0];
        y = MIX_MUL_LO;
      end
      2'd1: begin
        x = a_q[31:0];
        y = MIX_MUL_HI;
      end
      default: begin
        x = a_q[63:32];
        y = MIX_MUL_LO;
      end
    endcase
    prod = 64'(x) * 64'(y);
    if (step_q == 2'd0) begin
      acc_d = prod;
    end else begin
      acc_d = acc_q + {prod[31:0], 32'h0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 2'd0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      step_q <= 2'd0;
    end else if (busy_q) begin
      step_q <= step_q + 2'd1;
      if (step_q == LastStep) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.operand;
    end
    if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign rsp_o.busy    = busy_q;
  assign rsp_o.product = acc_q;

endmodule

FILE: src/case_folded_murmur64a_hash.sv
// Timing: a first word adds the length product, a last word adds the
// finalizer, and a finished hash may wait on hash_stall_i.
// Throughput: one word at a time, set by the shared multiplier that
// every multiply by the mix constant uses; word_stall_o holds off the
// next word until the current one is done.
// Reset: asynchronous, active low; clears seed, accumulator and output valid.
// ----------------------------------------------------------------------------
// case_folded_murmur64a_hash
// Seeded MurmurHash64A over case-folded little-endian words, with an
// APB-style seed register and valid/stall request channels.
// ----------------------------------------------------------------------------
module case_folded_murmur64a_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // input words
  input  logic        word_valid_i,
  output logic        word_stall_o,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        first_word_i,
  input  logic        last_word_i,
  input  logic [30:0] total_length_i,
  // result
  output logic        hash_valid_o,
  input  logic        hash_stall_i,
  output logic [63:0] hash_value_o
);
  import cmh_pkg::*;

  seq_state_e  state_q, state_d;
  logic [63:0] seed_q;
  logic [63:0] acc_q, acc_d;
  logic [63:0] k_q, k_d;
  logic [3:0]  cnt_q;
  logic        first_q, last_q;
  logic [30:0] len_q;
  logic [63:0] out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic [3:0]  cnt_clamped;
  mul_req_t    mreq;
  mul_rsp_t    mrsp;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == 1'b0) ? seed_q : 64'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= 64'h0;
    end else if (psel && penable && pwrite && paddr[3] == 1'b0) begin
      seed_q <= pwdata;
    end
  end

  assign word_stall_o = (state_q != ST_IDLE);
  assign accept       = word_valid_i && (state_q == ST_IDLE);
  assign cnt_clamped  = byte_count_i[3] ? 4'd8 : byte_count_i;

  cmh_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  always_comb begin
    state_d      = state_q;
    acc_d        = acc_q;
    k_d          = k_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && hash_stall_i;
    mreq.start   = 1'b0;
    mreq.operand = k_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          k_d     = fold_word(data_word_i, cnt_clamped);
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        if (first_q) begin
          mreq.start   = 1'b1;
          mreq.operand = {33'h0, len_q};
          state_d      = ST_LEN;
        end else begin
          state_d = ST_MIX;
        end
      end
      ST_LEN: begin
        if (!mrsp.busy) begin
          acc_d   = seed_q ^ mrsp.product;
          state_d = ST_MIX;
        end
      end
      ST_MIX: begin
        if (cnt_q == 4'd8) begin
          mreq.start   = 1'b1;
          mreq.operand = k_q;
          state_d      = ST_K1;
        end else if (cnt_q != 4'd0) begin
          // tail: h ^= k, h *= m
          acc_d        = acc_q ^ k_q;
          mreq.start   = 1'b1;
          mreq.operand = acc_q ^ k_q;
          state_d      = ST_H;
        end else begin
          state_d = ST_END;
        end
      end
      ST_K1: begin
        if (!mrsp.busy) begin
          k_d          = xor_shift(mrsp.product);
          mreq.start   = 1'b1;
          mreq.operand = xor_shift(mrsp.product);
          state_d      = ST_K2;
        end
      end
      ST_K2: begin
        if (!mrsp.busy) begin
          acc_d        = acc_q ^ mrsp.product;
          mreq.start   = 1'b1;
          mreq.operand = acc_q ^ mrsp.product;
          state_d      = ST_H;
        end
      end
      ST_H: begin
        if (!mrsp.busy) begin
          acc_d   = mrsp.product;
          state_d = ST_END;
        end
      end
      ST_END: begin
        if (last_q) begin
          mreq.start   = 1'b1;
          mreq.operand = xor_shift(acc_q);
          state_d      = ST_FIN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!mrsp.busy && !(out_valid_q && hash_stall_i)) begin
          out_d       = xor_shift(mrsp.product);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= 64'h0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    out_q <= out_d;
    if (accept) begin
      cnt_q   <= cnt_clamped;
      first_q <= first_word_i;
      last_q  <= last_word_i;
      len_q   <= total_length_i;
    end
  end

  assign hash_valid_o = out_valid_q;
  assign hash_value_o = out_q;

endmodule

FILE: tb/tb_case_folded_murmur64a_hash.sv
// ----------------------------------------------------------------------------
// tb_case_folded_murmur64a_hash
// Self-checking bench for the case-folded MurmurHash64A block. A directed
// table covers the field extremes and the odd corners: empty strings, counts
// above eight, tail words mid-string, missing first marks, and bad lengths.
// Then randomly generated strings and stray words run under several seeds,
// with random gaps and stalls on both channels. Every hash is checked against
// an in-bench model of the folding and the mixing, or against a pinned value.
// ----------------------------------------------------------------------------
module tb_case_folded_murmur64a_hash;
  import cmh_pkg::*;

  localparam int unsigned REG_SEED      = 0;
  localparam int unsigned LIMIT         = 600000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_WORDS   = 250;
  localparam int unsigned DIR_ROWS      = 20;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        first;
    logic        last;
    logic [30:0] len;
  } word_req_t;

  // directed row; pinned rows carry a hash that is obvious by inspection
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        first;
    logic        last;
    logic [30:0] len;
    logic        pinned;
    logic [63:0] hash;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        word_valid = 1'b0;
  logic        word_stall_o;
  word_req_t   word_req = '0;
  logic        hash_valid_o;
  logic        hash_stall_i = 1'b0;
  logic [63:0] hash_value_o;

  // model state
  logic [63:0] mix_seed = '0;
  logic [63:0] mix_acc = '0;
  logic [63:0] hash_q[$];

  bit          idle_on = 1'b1;
  bit          hold_go = 1'b0;
  int unsigned fail_count = 0;
  int unsigned hashes_seen = 0;
  int unsigned words_sent = 0;
  int unsigned phase_words = 0;
  int unsigned strings_sent = 0;
  int unsigned stray_sent = 0;
  int unsigned cycle_count = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // empty string, zero seed and length: everything stays zero
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 1'b1, 31'd0, 1'b1, 64'h0},
    // no first mark, length ignored, accumulator still zero
    '{64'h0, 4'd0, 1'b0, 1'b1, 31'h7FFF_FFFF, 1'b1, 64'h0},
    '{64'h4847_4645_4443_4241, 4'd8, 1'b1, 1'b1, 31'd8, 1'b0, 64'h0},
    '{64'h6867_6665_6463_6261, 4'd8, 1'b1, 1'b1, 31'd8, 1'b0, 64'h0},
    '{64'h7B7A_6160_5B5A_4140, 4'd8, 1'b1, 1'b1, 31'd8, 1'b0, 64'h0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b1, 31'h7FFF_FFFF, 1'b0, 64'h0},
    '{64'h0, 4'd8, 1'b1, 1'b1, 31'd0, 1'b0, 64'h0},
    '{64'h0123_4567_89AB_CDEF, 4'd15, 1'b1, 1'b1, 31'd8, 1'b0, 64'h0},
    '{64'h0123_4567_89AB_CDEF, 4'd9, 1'b1, 1'b1, 31'd8, 1'b0, 64'h0},
    // short word mid-string, then hashing goes on from it
    '{64'h5A5A_5A5A_5A5A_5A5A, 4'd3, 1'b1, 1'b0, 31'd11, 1'b0, 64'h0},
    '{64'h4142_4344_4546_4748, 4'd8, 1'b0, 1'b1, 31'd0, 1'b0, 64'h0},
    '{64'h2020_4F4C_4C45_4820, 4'd8, 1'b1, 1'b0, 31'd21, 1'b0, 64'h0},
    '{64'h6F57_2021_444C_524F, 4'd8, 1'b0, 1'b0, 31'd0, 1'b0, 64'h0},
    '{64'hDEAD_BEEF_FF41_4243, 4'd5, 1'b0, 1'b1, 31'd0, 1'b0, 64'h0},
    // length disagrees with the bytes sent
    '{64'h0000_0000_7A61_5A41, 4'd4, 1'b1, 1'b1, 31'd1000, 1'b0, 64'h0},
    '{64'hFFFF_FFFF_FFFF_4A4B, 4'd2, 1'b0, 1'b1, 31'd5, 1'b0, 64'h0},
    '{64'hAAAA_AAAA_AAAA_AA5A, 4'd1, 1'b1, 1'b1, 31'd1, 1'b0, 64'h0},
    '{64'h8041_5B60_7B40_5A61, 4'd7, 1'b1, 1'b1, 31'd7, 1'b0, 64'h0},
    '{64'h1234_5678_9ABC_DEF0, 4'd0, 1'b0, 1'b0, 31'd3, 1'b0, 64'h0},
    '{64'h0FED_CBA9_8765_4321, 4'd0, 1'b0, 1'b1, 31'd0, 1'b0, 64'h0}
  };

  case_folded_murmur64a_hash dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .word_valid_i   (word_valid),
    .word_stall_o   (word_stall_o),
    .data_word_i    (word_req.data),
    .byte_count_i   (word_req.count),
    .first_word_i   (word_req.first),
    .last_word_i    (word_req.last),
    .total_length_i (word_req.len),
    .hash_valid_o   (hash_valid_o),
    .hash_stall_i   (hash_stall_i),
    .hash_value_o   (hash_value_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] ascii_lower(input logic [63:0] w, input logic [3:0] n);
    logic [63:0] res;
    logic [7:0]  b;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      b = w[8*i +: 8];
      if (i >= n) begin
        b = 8'h00;
      end else if (b >= 8'h41 && b <= 8'h5A) begin
        b = b | 8'h20;
      end
      res[8*i +: 8] = b;
    end
    return res;
  endfunction

  // advances the model by one accepted word; queues a hash on a last word
  task automatic hash_word(input word_req_t r, input bit pinned, input logic [63:0] pin);
    logic [63:0] h;
    logic [63:0] k;
    logic [3:0]  n;
    n = (r.count > 4'd8) ? 4'd8 : r.count;
    h = r.first ? (mix_seed ^ (64'(r.len) * MIX_MUL)) : mix_acc;
    k = ascii_lower(r.data, n);
    if (n == 4'd8) begin
      k = k * MIX_MUL;
      k = k ^ (k >> MIX_SHIFT);
      k = k * MIX_MUL;
      h = (h ^ k) * MIX_MUL;
    end else if (n != 4'd0) begin
      h = (h ^ k) * MIX_MUL;
    end
    mix_acc = h;
    if (r.last) begin
      h = h ^ (h >> MIX_SHIFT);
      h = h * MIX_MUL;
      h = h ^ (h >> MIX_SHIFT);
      hash_q.push_back(pinned ? pin : h);
    end
  endtask

  // called at a rising edge; returns at the edge the request is taken
  task automatic push_word(input word_req_t r, input bit pinned, input logic [63:0] pin);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      word_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    word_valid <= 1'b1;
    word_req   <= r;
    do @(posedge clk_i); while (word_stall_o);
    hash_word(r, pinned, pin);
    words_sent++;
    phase_words++;
  endtask

  // write the seed, then read it straight back in a second transfer
  task automatic write_seed(input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(8 * REG_SEED);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value) begin
      $error("seed: expected %h, actual %h", value, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    mix_seed = value;
  endtask

  // wait for every hash, then for any word still in the mixer
  task automatic settle();
    word_valid <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // text-like bytes, heavy on letters and the fold boundaries
  function automatic logic [63:0] text_word();
    logic [63:0]  w;
    logic [7:0]   edges [8];
    edges = '{8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(0, 3))
        0:       w[8*i +: 8] = 8'($urandom_range(8'h41, 8'h5A));
        1:       w[8*i +: 8] = 8'($urandom_range(8'h61, 8'h7A));
        2:       w[8*i +: 8] = edges[$urandom_range(0, 7)];
        default: w[8*i +: 8] = 8'($urandom);
      endcase
    end
    return w;
  endfunction

  task automatic send_string(input int unsigned nbytes);
    word_req_t   r;
    int unsigned remain;
    int unsigned take;
    logic [30:0] len_field;
    case ($urandom_range(0, 19))
      0:       len_field = 31'($urandom);
      1:       len_field = 31'h7FFF_FFFF;
      default: len_field = 31'(nbytes);
    endcase
    strings_sent++;
    r.first = 1'b1;
    r.len   = len_field;
    if (nbytes == 0) begin
      r.data  = {$urandom, $urandom};
      r.count = 4'd0;
      r.last  = 1'b1;
      push_word(r, 1'b0, '0);
    end else begin
      remain = nbytes;
      while (remain > 0) begin
        take    = (remain >= 8) ? 8 : remain;
        r.data  = text_word();
        r.count = 4'(take);
        if (take == 8 && $urandom_range(0, 9) == 0) begin
          r.count = 4'($urandom_range(9, 15));
        end
        r.last = (remain <= 8);
        push_word(r, 1'b0, '0);
        remain  = remain - take;
        r.first = 1'b0;
      end
    end
  endtask

  // result side: check against the oldest queued hash, then pick next stall
  always @(posedge clk_i) begin
    static int unsigned stall_left = 0;
    static int unsigned hold_left = 0;
    static bit          hold_done = 1'b0;
    logic [63:0]        want;
    if (hash_valid_o && !hash_stall_i) begin
      hashes_seen++;
      if (hash_q.size() == 0) begin
        $error("hash_value: no request pending, actual %h", hash_value_o);
        fail_count++;
      end else begin
        want = hash_q.pop_front();
        if (hash_value_o !== want) begin
          $error("hash_value: expected %h, actual %h", want, hash_value_o);
          fail_count++;
        end
      end
    end
    if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      hash_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      hash_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      hash_stall_i <= 1'b1;
    end else begin
      hash_stall_i <= 1'b0;
    end
  end

  initial begin
    word_req_t   r;
    logic [63:0] seed_val;
    int unsigned nbytes;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table runs on the reset seed
    for (int i = 0; i < DIR_ROWS; i++) begin
      r = '{dir_rows[i].data, dir_rows[i].count, dir_rows[i].first,
            dir_rows[i].last, dir_rows[i].len};
      push_word(r, dir_rows[i].pinned, dir_rows[i].hash);
    end
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       seed_val = 64'hFFFF_FFFF_FFFF_FFFF;
        1:       seed_val = 64'h0;
        3:       seed_val = 64'h8000_0000_0000_0001;
        default: seed_val = {$urandom, $urandom};
      endcase
      write_seed(seed_val);
      if (p == 1) begin
        hold_go <= 1'b1;
      end
      if (p == PHASES - 1) begin
        idle_on = 1'b0;
      end
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        if ($urandom_range(0, 99) < 15) begin
          r = '{{$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'($urandom),
                1'($urandom), 31'($urandom)};
          stray_sent++;
          push_word(r, 1'b0, '0);
        end else begin
          case ($urandom_range(0, 19))
            0:       nbytes = $urandom_range(81, 300);
            1, 2, 3, 4, 5: nbytes = $urandom_range(25, 80);
            default: nbytes = $urandom_range(0, 24);
          endcase
          send_string(nbytes);
        end
      end
      settle();
    end

    $display("Ran %0d words: %0d strings and %0d stray words, reset seed plus %0d seeds",
             words_sent, strings_sent, stray_sent, PHASES);
    $display("Checked %0d hashes, with a %0d-cycle output hold-off to back up the input",
             hashes_seen, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
